// ===== sv/assert_macros.svh =====
// assertion helpers used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off while reset is asserted
`define ASSERT_IMPLIES(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while reset is asserted
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/jtl_pkg.sv =====
package jtl_pkg;

    // text length limit and derived position widths
    localparam int MAX_TEXT_LEN = 65536;
    localparam int POS_W        = $clog2(MAX_TEXT_LEN + 1);
    localparam int TS_W         = $clog2(MAX_TEXT_LEN);
    localparam int EXT_W        = (POS_W + 1 > 17) ? POS_W + 1 : 17;

    // output field widths and saturation limits
    localparam int START_W   = 16;
    localparam int AFTER_W   = 17;
    localparam int START_SAT = 65535;
    localparam int AFTER_SAT = 65536;

    // results per character and the bundle queue
    localparam int MAX_RES    = 3;
    localparam int CNT_W      = $clog2(MAX_RES + 1);
    localparam int FIFO_DEPTH = 4;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);

    // character codes
    localparam logic [7:0] CH_LBRACK = 8'h5B;
    localparam logic [7:0] CH_RBRACK = 8'h5D;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_DIG_LO = 8'h30;
    localparam logic [7:0] CH_DIG_HI = 8'h39;
    localparam logic [7:0] CH_UC_LO  = 8'h41;
    localparam logic [7:0] CH_UC_HI  = 8'h5A;
    localparam logic [7:0] CH_LC_LO  = 8'h61;
    localparam logic [7:0] CH_LC_HI  = 8'h7A;

    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_STRING,
        MODE_NUMBER,
        MODE_WORD,
        MODE_ERROR
    } mode_t;

    typedef enum logic [3:0] {
        KIND_LBRACK = 4'd0,
        KIND_RBRACK = 4'd1,
        KIND_COMMA  = 4'd2,
        KIND_LBRACE = 4'd3,
        KIND_COLON  = 4'd4,
        KIND_RBRACE = 4'd5,
        KIND_STRING = 4'd6,
        KIND_NUMBER = 4'd7,
        KIND_WORD   = 4'd8,
        KIND_END    = 4'd9,
        KIND_ERROR  = 4'd10
    } kind_t;

    typedef enum logic [2:0] {
        ERR_NONE      = 3'd0,
        ERR_NUL       = 3'd1,
        ERR_UNEXPECT  = 3'd2,
        ERR_UNTERM    = 3'd3,
        ERR_TOO_LONG  = 3'd4
    } err_t;

    typedef struct packed {
        kind_t              kind;
        err_t               err;
        logic [START_W-1:0] start;
        logic [AFTER_W-1:0] after;
    } tok_t;

    // all results caused by one character
    typedef struct packed {
        logic [CNT_W-1:0]       cnt;
        tok_t [MAX_RES-1:0]     toks;
    } bundle_t;

    // one queue slot with its valid flag
    typedef struct packed {
        logic    valid;
        bundle_t bundle;
    } qslot_t;

    function automatic logic is_space(input logic [7:0] c);
        return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= CH_DIG_LO && c <= CH_DIG_HI;
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= CH_UC_LO && c <= CH_UC_HI) || (c >= CH_LC_LO && c <= CH_LC_HI);
    endfunction

    function automatic logic is_quote(input logic [7:0] c);
        return (c == CH_SQUOTE) || (c == CH_DQUOTE);
    endfunction

    function automatic logic is_punct(input logic [7:0] c);
        return (c == CH_LBRACK) || (c == CH_RBRACK) || (c == CH_COMMA) ||
               (c == CH_LBRACE) || (c == CH_COLON) || (c == CH_RBRACE);
    endfunction

    function automatic kind_t punct_kind(input logic [7:0] c);
        kind_t k;
        k = KIND_RBRACE;
        priority case (c)
            CH_LBRACK: k = KIND_LBRACK;
            CH_RBRACK: k = KIND_RBRACK;
            CH_COMMA:  k = KIND_COMMA;
            CH_LBRACE: k = KIND_LBRACE;
            CH_COLON:  k = KIND_COLON;
            default:   k = KIND_RBRACE;
        endcase
        return k;
    endfunction

    // build a result with saturated positions
    function automatic tok_t mk_tok(input kind_t kind, input err_t err,
                                    input logic [EXT_W-1:0] s,
                                    input logic [EXT_W-1:0] a);
        tok_t t;
        t.kind  = kind;
        t.err   = err;
        t.start = (s > EXT_W'(START_SAT)) ? START_W'(START_SAT) : s[START_W-1:0];
        t.after = (a > EXT_W'(AFTER_SAT)) ? AFTER_W'(AFTER_SAT) : a[AFTER_W-1:0];
        return t;
    endfunction

endpackage

// ===== sv/jtl_front.sv =====
module jtl_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic [7:0]            s_char_code,
    input  logic                  s_last_of_text,
    input  logic                  q_full,
    output jtl_pkg::qslot_t       q_push
);

    jtl_pkg::mode_t                 mode_reg, mode_next;
    logic                           qd_reg, qd_next;
    logic                           bs_reg, bs_next;
    logic [jtl_pkg::TS_W-1:0]       ts_reg, ts_next;
    logic [jtl_pkg::POS_W-1:0]      pos_reg, pos_next;

    logic                           accept;
    logic                           do_start;
    logic                           too_long;
    logic [jtl_pkg::CNT_W-1:0]      n;
    jtl_pkg::bundle_t               bundle;
    logic [jtl_pkg::EXT_W-1:0]      p_ext, p1_ext, ts_ext;
    logic [7:0]                     close_q;
    logic [7:0]                     c;

    assign c        = s_char_code;
    assign s_ready  = !q_full;
    assign accept   = s_valid && s_ready;
    assign p_ext    = jtl_pkg::EXT_W'(pos_reg);
    assign p1_ext   = p_ext + jtl_pkg::EXT_W'(1);
    assign ts_ext   = jtl_pkg::EXT_W'(ts_reg);
    assign close_q  = qd_reg ? jtl_pkg::CH_DQUOTE : jtl_pkg::CH_SQUOTE;
    assign too_long = pos_reg >= jtl_pkg::POS_W'(jtl_pkg::MAX_TEXT_LEN);

    // classify the character and collect its results
    always_comb begin
        mode_next = mode_reg;
        qd_next   = qd_reg;
        bs_next   = bs_reg;
        ts_next   = ts_reg;
        pos_next  = pos_reg;
        do_start  = 1'b0;
        n         = '0;
        bundle    = '0;

        if (too_long) begin
            if (mode_reg != jtl_pkg::MODE_ERROR) begin
                bundle.toks[n] = jtl_pkg::mk_tok(jtl_pkg::KIND_ERROR,
                                                 jtl_pkg::ERR_TOO_LONG, p_ext, p1_ext);
                n = n + jtl_pkg::CNT_W'(1);
                mode_next = jtl_pkg::MODE_ERROR;
            end
        end else begin
            unique case (mode_reg)
                jtl_pkg::MODE_STRING: begin
                    if (c == close_q && !bs_reg) begin
                        bundle.toks[n] = jtl_pkg::mk_tok(jtl_pkg::KIND_STRING,
                                                         jtl_pkg::ERR_NONE, ts_ext, p1_ext);
                        n = n + jtl_pkg::CNT_W'(1);
                        mode_next = jtl_pkg::MODE_IDLE;
                        bs_next   = 1'b0;
                    end else begin
                        bs_next = (c == jtl_pkg::CH_BSLASH);
                    end
                end
                jtl_pkg::MODE_NUMBER: begin
                    if (!(jtl_pkg::is_alpha(c) || jtl_pkg::is_digit(c) ||
                          c == jtl_pkg::CH_DOT)) begin
                        bundle.toks[n] = jtl_pkg::mk_tok(jtl_pkg::KIND_NUMBER,
                                                         jtl_pkg::ERR_NONE, ts_ext, p_ext);
                        n = n + jtl_pkg::CNT_W'(1);
                        mode_next = jtl_pkg::MODE_IDLE;
                        do_start  = 1'b1;
                    end
                end
                jtl_pkg::MODE_WORD: begin
                    if (jtl_pkg::is_space(c) || jtl_pkg::is_punct(c) ||
                        jtl_pkg::is_quote(c)) begin
                        bundle.toks[n] = jtl_pkg::mk_tok(jtl_pkg::KIND_WORD,
                                                         jtl_pkg::ERR_NONE, ts_ext, p_ext);
                        n = n + jtl_pkg::CNT_W'(1);
                        mode_next = jtl_pkg::MODE_IDLE;
                        do_start  = 1'b1;
                    end
                end
                jtl_pkg::MODE_IDLE: begin
                    do_start = 1'b1;
                end
                jtl_pkg::MODE_ERROR: begin
                    mode_next = jtl_pkg::MODE_ERROR;
                end
                default: begin
                    mode_next = jtl_pkg::MODE_ERROR;
                end
            endcase
        end

        // character that opens a new token
        if (do_start) begin
            if (jtl_pkg::is_space(c)) begin
                mode_next = jtl_pkg::MODE_IDLE;
            end else if (c == jtl_pkg::CH_NUL) begin
                bundle.toks[n] = jtl_pkg::mk_tok(jtl_pkg::KIND_ERROR,
                                                 jtl_pkg::ERR_NUL, p_ext, p1_ext);
                n = n + jtl_pkg::CNT_W'(1);
                mode_next = jtl_pkg::MODE_ERROR;
            end else if (jtl_pkg::is_punct(c)) begin
                bundle.toks[n] = jtl_pkg::mk_tok(jtl_pkg::punct_kind(c),
                                                 jtl_pkg::ERR_NONE, p_ext, p1_ext);
                n = n + jtl_pkg::CNT_W'(1);
            end else begin
                ts_next = pos_reg[jtl_pkg::TS_W-1:0];
                if (jtl_pkg::is_quote(c)) begin
                    mode_next = jtl_pkg::MODE_STRING;
                    qd_next   = (c == jtl_pkg::CH_DQUOTE);
                    bs_next   = 1'b0;
                end else if (c == jtl_pkg::CH_MINUS || jtl_pkg::is_digit(c)) begin
                    mode_next = jtl_pkg::MODE_NUMBER;
                end else if (jtl_pkg::is_alpha(c)) begin
                    mode_next = jtl_pkg::MODE_WORD;
                end else begin
                    bundle.toks[n] = jtl_pkg::mk_tok(jtl_pkg::KIND_ERROR,
                                                     jtl_pkg::ERR_UNEXPECT, p_ext, p1_ext);
                    n = n + jtl_pkg::CNT_W'(1);
                    mode_next = jtl_pkg::MODE_ERROR;
                end
            end
        end

        // end of text flushes any pending token and restarts
        if (s_last_of_text) begin
            if (mode_next == jtl_pkg::MODE_STRING) begin
                bundle.toks[n] = jtl_pkg::mk_tok(jtl_pkg::KIND_ERROR,
                                                 jtl_pkg::ERR_UNTERM,
                                                 jtl_pkg::EXT_W'(ts_next), p1_ext);
                n = n + jtl_pkg::CNT_W'(1);
            end else if (mode_next == jtl_pkg::MODE_NUMBER) begin
                bundle.toks[n] = jtl_pkg::mk_tok(jtl_pkg::KIND_NUMBER,
                                                 jtl_pkg::ERR_NONE,
                                                 jtl_pkg::EXT_W'(ts_next), p1_ext);
                n = n + jtl_pkg::CNT_W'(1);
            end else if (mode_next == jtl_pkg::MODE_WORD) begin
                bundle.toks[n] = jtl_pkg::mk_tok(jtl_pkg::KIND_WORD,
                                                 jtl_pkg::ERR_NONE,
                                                 jtl_pkg::EXT_W'(ts_next), p1_ext);
                n = n + jtl_pkg::CNT_W'(1);
            end
            bundle.toks[n] = jtl_pkg::mk_tok(jtl_pkg::KIND_END, jtl_pkg::ERR_NONE,
                                             p1_ext, p1_ext);
            n = n + jtl_pkg::CNT_W'(1);
            mode_next = jtl_pkg::MODE_IDLE;
            qd_next   = 1'b0;
            bs_next   = 1'b0;
            ts_next   = '0;
            pos_next  = '0;
        end else if (!too_long) begin
            pos_next = pos_reg + jtl_pkg::POS_W'(1);
        end

        bundle.cnt = n;
    end

    // push only characters that produced results
    assign q_push.valid  = accept && (n != '0);
    assign q_push.bundle = bundle;

    // lexer state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= jtl_pkg::MODE_IDLE;
            qd_reg   <= 1'b0;
            bs_reg   <= 1'b0;
            ts_reg   <= '0;
            pos_reg  <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            qd_reg   <= qd_next;
            bs_reg   <= bs_next;
            ts_reg   <= ts_next;
            pos_reg  <= pos_next;
        end
    end

endmodule

// ===== sv/jtl_queue.sv =====
module jtl_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  jtl_pkg::qslot_t   q_push,
    output logic              q_full,
    input  logic              q_pop,
    output jtl_pkg::qslot_t   q_head
);

    jtl_pkg::bundle_t            mem_reg [jtl_pkg::FIFO_DEPTH];
    logic [jtl_pkg::PTR_W:0]     wr_ptr_reg, rd_ptr_reg;
    logic                        empty;

    assign empty  = (wr_ptr_reg == rd_ptr_reg);
    assign q_full = (wr_ptr_reg[jtl_pkg::PTR_W] != rd_ptr_reg[jtl_pkg::PTR_W]) &&
                    (wr_ptr_reg[jtl_pkg::PTR_W-1:0] == rd_ptr_reg[jtl_pkg::PTR_W-1:0]);

    assign q_head.valid  = !empty;
    assign q_head.bundle = mem_reg[rd_ptr_reg[jtl_pkg::PTR_W-1:0]];

    // bundle storage
    always_ff @(posedge aclk) begin
        if (q_push.valid && !q_full) begin
            mem_reg[wr_ptr_reg[jtl_pkg::PTR_W-1:0]] <= q_push.bundle;
        end
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
        end else begin
            if (q_push.valid && !q_full) begin
                wr_ptr_reg <= wr_ptr_reg + (jtl_pkg::PTR_W + 1)'(1);
            end
            if (q_pop && !empty) begin
                rd_ptr_reg <= rd_ptr_reg + (jtl_pkg::PTR_W + 1)'(1);
            end
        end
    end

endmodule

// ===== sv/jtl_back.sv =====
module jtl_back (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  jtl_pkg::qslot_t                q_head,
    output logic                           q_pop,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [3:0]                     m_token_kind,
    output logic [2:0]                     m_error_code,
    output logic [jtl_pkg::START_W-1:0]    m_start_pos,
    output logic [jtl_pkg::AFTER_W-1:0]    m_after_pos,
    output logic                           m_last_result
);

    logic [jtl_pkg::CNT_W-1:0]  sub_reg, sub_next;
    logic                       m_valid_reg;
    jtl_pkg::tok_t              tok_reg;
    logic                       last_reg;
    logic                       load;
    logic                       is_last;
    jtl_pkg::tok_t              cur;

    // pick the next result from the head bundle
    assign cur     = q_head.bundle.toks[sub_reg];
    assign is_last = (sub_reg == q_head.bundle.cnt - jtl_pkg::CNT_W'(1));
    assign load    = q_head.valid && (!m_valid_reg || m_ready);
    assign q_pop   = load && is_last;

    always_comb begin
        sub_next = sub_reg;
        if (load) begin
            sub_next = is_last ? '0 : sub_reg + jtl_pkg::CNT_W'(1);
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            sub_reg     <= '0;
        end else begin
            sub_reg <= sub_next;
            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            tok_reg  <= cur;
            last_reg <= is_last;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_token_kind  = tok_reg.kind;
    assign m_error_code  = tok_reg.err;
    assign m_start_pos   = tok_reg.start;
    assign m_after_pos   = tok_reg.after;
    assign m_last_result = last_reg;

endmodule

// ===== sv/json_token_lexer_top.sv =====
// json token lexer: one character per transaction, up to three results per character
// throughput: one character per cycle while each character gives at most one result and
// m_ready stays high; the result side emits one result per cycle while m_ready is high
// path: a character's results reach m_ through the bundle queue and the output register
// (bundle written to the four-entry queue at acceptance, then the output register loads it)
// reset: synchronous active-low aresetn clears lexer state, queue pointers and m_valid
`include "assert_macros.svh"

module json_token_lexer_top (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  logic [7:0]   s_char_code,
    input  logic         s_last_of_text,
    output logic         m_valid,
    input  logic         m_ready,
    output logic [3:0]   m_token_kind,
    output logic [2:0]   m_error_code,
    output logic [15:0]  m_start_pos,
    output logic [16:0]  m_after_pos,
    output logic         m_last_result
);

    jtl_pkg::qslot_t  q_push;
    jtl_pkg::qslot_t  q_head;
    logic             q_full;
    logic             q_pop;

    logic             head_cnt_zero;
    logic             res_is_err;
    logic             res_has_code;
    logic             res_is_end;

    // front: classify characters and track lexer mode
    jtl_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_code    (s_char_code),
        .s_last_of_text (s_last_of_text),
        .q_full         (q_full),
        .q_push         (q_push)
    );

    // bundle queue between front and back
    jtl_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_full  (q_full),
        .q_pop   (q_pop),
        .q_head  (q_head)
    );

    // back: serialize bundles into result transactions
    jtl_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_token_kind  (m_token_kind),
        .m_error_code  (m_error_code),
        .m_start_pos   (m_start_pos),
        .m_after_pos   (m_after_pos),
        .m_last_result (m_last_result)
    );

    // result classification for the checks
    assign head_cnt_zero = (q_head.bundle.cnt == '0);
    assign res_is_err    = (m_token_kind == jtl_pkg::KIND_ERROR);
    assign res_has_code  = (m_error_code != jtl_pkg::ERR_NONE);
    assign res_is_end    = (m_token_kind == jtl_pkg::KIND_END);

    // checks
    `ASSERT_IMPLIES(a_no_overflow, aclk, aresetn, q_push.valid, !q_full, "queue overflow")
    `ASSERT_IMPLIES(a_head_nonempty, aclk, aresetn, q_head.valid, !head_cnt_zero, "empty bundle")
    `ASSERT_IMPLIES(a_err_code, aclk, aresetn, m_valid, res_is_err == res_has_code, "bad err code")
    `ASSERT_IMPLIES(a_end_last, aclk, aresetn, m_valid && res_is_end, m_last_result, "end not last")

endmodule
